@@ sv/jfps_pkg.sv @@
// Shared constants and types for the four-point Jacobi stencil block.
package jfps_pkg;

  localparam int unsigned MAX_PADDED_COLS = 1024;
  localparam int unsigned COL_W           = $clog2(MAX_PADDED_COLS);
  localparam int unsigned ROW_W           = 17;
  localparam int unsigned ROWS_W          = 16;
  localparam int unsigned COLS_W          = 10;
  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned CFG_ADDR_W      = 1;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [COLS_W-1:0] COLS_LIMIT = COLS_W'(MAX_PADDED_COLS - 2);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INTERIOR_ROWS = 1'b0,
    REG_INTERIOR_COLS = 1'b1
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

@@ sv/jfps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module jfps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/jacobi_four_point_stencil.sv @@
// Streaming Jacobi four-point sweep over a padded grid with two line buffers.
//
// Usage:
//   in_*  : one padded-grid sample per request, raster order, signed Q16.16.
//   out_* : one result per interior point, the floored mean of its left,
//           right, upper and lower neighbours; out_tlast marks the final
//           interior point of a grid, after which the counters restart.
//   cfg_* : interior_rows (index 0) and interior_cols (index 1), written
//           while the block is idle; columns above 1022 are clamped.
// Throughput: one sample per cycle while in_tready is high. The line
//   buffers are prefetched from the next column count, so the three RAM
//   read ports keep pace with back-to-back requests.
// Latency: a result is registered into out_* on acceptance of the sample
//   that is its lower neighbour, or into the skid entry if out_* stalls.
// Stall: an output register plus one skid entry; in_tready drops only
//   when both hold results. Samples that make no result still need a
//   free skid entry.
// Reset: counters and output valids clear; rows and cols reset to 1.
//   Line buffers are not cleared and hold garbage until the first rows.
module jacobi_four_point_stencil (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [jfps_pkg::SAMPLE_W-1:0]     in_tdata,   // [31:0] sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [jfps_pkg::SAMPLE_W-1:0]     out_tdata,  // [31:0] average
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [jfps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [jfps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned COL_W  = jfps_pkg::COL_W;
  localparam int unsigned ROW_W  = jfps_pkg::ROW_W;
  localparam int unsigned ROWS_W = jfps_pkg::ROWS_W;
  localparam int unsigned COLS_W = jfps_pkg::COLS_W;
  localparam int unsigned SW     = jfps_pkg::SAMPLE_W;

  logic [ROWS_W-1:0] rows_r;
  logic [COLS_W-1:0] cols_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COLS_W-1:0] ncols;
  logic [ROW_W-1:0]  nrows_p1;
  logic [COLS_W:0]   ncols_p1;
  logic              acc, wrap, produce, is_last;
  logic [COL_W-1:0]  rd_addr_a, rd_addr_b;

  jfps_pkg::sample_t mid_a_rdata, mid_b_rdata, up_rdata;
  jfps_pkg::sample_t byp_r, left_r, right_val;
  logic              hit_r;
  logic [SW+1:0]     sum;
  jfps_pkg::sample_t avg;

  logic              out_v_r, skid_v_r;
  jfps_pkg::sample_t out_d_r, skid_d_r;
  logic              out_l_r, skid_l_r;
  logic              out_take;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_W'(1);
      cols_r <= COLS_W'(1);
    end else if (cfg_we) begin
      case (jfps_pkg::cfg_reg_t'(cfg_addr))
        jfps_pkg::REG_INTERIOR_ROWS: rows_r <= cfg_wdata[ROWS_W-1:0];
        jfps_pkg::REG_INTERIOR_COLS: cols_r <= cfg_wdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign ncols    = (cols_r > jfps_pkg::COLS_LIMIT) ? jfps_pkg::COLS_LIMIT : cols_r;
  assign ncols_p1 = {1'b0, ncols} + (COLS_W+1)'(1);
  assign nrows_p1 = {1'b0, rows_r} + ROW_W'(1);

  // Position counters
  assign acc  = in_tvalid && in_tready;
  assign wrap = ({1'b0, col_r} >= ncols_p1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = (row_r >= nrows_p1) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line buffers: prefetch the entries for the next sample
  assign rd_addr_a = col_nxt;
  assign rd_addr_b = col_nxt + COL_W'(1);

  jfps_ram #(.WIDTH(SW), .DEPTH(jfps_pkg::MAX_PADDED_COLS)) u_mid_a (
    .clk  (clk),
    .we   (acc),
    .waddr(col_r),
    .wdata(in_tdata),
    .raddr(rd_addr_a),
    .rdata(mid_a_rdata)
  );

  jfps_ram #(.WIDTH(SW), .DEPTH(jfps_pkg::MAX_PADDED_COLS)) u_mid_b (
    .clk  (clk),
    .we   (acc),
    .waddr(col_r),
    .wdata(in_tdata),
    .raddr(rd_addr_b),
    .rdata(mid_b_rdata)
  );

  jfps_ram #(.WIDTH(SW), .DEPTH(jfps_pkg::MAX_PADDED_COLS)) u_upper (
    .clk  (clk),
    .we   (acc),
    .waddr(col_r),
    .wdata(mid_a_rdata),
    .raddr(rd_addr_a),
    .rdata(up_rdata)
  );

  // Forward a sample written to the entry read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= acc && (rd_addr_b == col_r);
    end
  end

  always_ff @(posedge clk) begin
    byp_r <= in_tdata;
    if (acc) begin
      left_r <= mid_a_rdata;
    end
  end

  assign right_val = hit_r ? byp_r : mid_b_rdata;

  // Mean of four neighbours
  assign sum = {{2{left_r[SW-1]}}, left_r} + {{2{right_val[SW-1]}}, right_val}
             + {{2{up_rdata[SW-1]}}, up_rdata} + {{2{in_tdata[SW-1]}}, in_tdata};
  assign avg = sum[SW+1:2];

  assign produce = (row_r >= ROW_W'(2)) && (row_r <= nrows_p1) &&
                   (col_r != '0) && ({1'b0, col_r} <= {1'b0, ncols});
  assign is_last = (row_r == nrows_p1) && (col_r == ncols);

  // Output register and skid entry
  assign out_take  = out_v_r && out_tready;
  assign in_tready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (acc && produce) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_d_r <= skid_d_r;
        out_l_r <= skid_l_r;
      end
    end else if (acc && produce) begin
      if (out_v_r && !out_tready) begin
        skid_d_r <= avg;
        skid_l_r <= is_last;
      end else begin
        out_d_r <= avg;
        out_l_r <= is_last;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

endmodule

@@ sv/jfps_chk.sv @@
// Port-level checker for the four-point Jacobi stencil block, with its bind.
module jfps_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [jfps_pkg::SAMPLE_W-1:0] out_tdata,
  input logic out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("outputs not idle after reset");

  a_backpressure_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  a_ready_falls_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

endmodule

bind jacobi_four_point_stencil jfps_chk u_jfps_chk (.*);

@@ sim/jacobi_four_point_stencil_test.sv @@
// Testbench for the four-point Jacobi stencil: streams padded grids, predicts each average.
module jacobi_four_point_stencil_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PADDED_COLS = jfps_pkg::MAX_PADDED_COLS;
  localparam int unsigned ROW_W           = jfps_pkg::ROW_W;
  localparam int unsigned ROWS_W          = jfps_pkg::ROWS_W;
  localparam int unsigned COLS_W          = jfps_pkg::COLS_W;
  localparam int unsigned SAMPLE_W        = jfps_pkg::SAMPLE_W;
  localparam int unsigned CFG_ADDR_W      = jfps_pkg::CFG_ADDR_W;
  localparam int unsigned CFG_DATA_W      = jfps_pkg::CFG_DATA_W;
  localparam logic [COLS_W-1:0] COLS_LIMIT = jfps_pkg::COLS_LIMIT;

  typedef jfps_pkg::sample_t sample_t;

  localparam sample_t MOST_POS = 32'h7FFF_FFFF;
  localparam sample_t MOST_NEG = 32'h8000_0000;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_SAMPLES = 240;

  typedef struct {
    sample_t average;
    logic    is_last;
  } stencil_result_t;

  class stencil_scoreboard;
    sample_t           upper_row [MAX_PADDED_COLS];
    sample_t           middle_row [MAX_PADDED_COLS];
    logic [ROW_W-1:0]  row_pos;
    logic [COLS_W-1:0] col_pos;
    sample_t           left_val;
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    stencil_result_t   pending[$];
    int unsigned       errors;
    int unsigned       samples_seen;
    int unsigned       results_seen;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      row_pos  = '0;
      col_pos  = '0;
      left_val = '0;
      rows     = ROWS_W'(1);
      cols     = COLS_W'(1);
    endfunction

    function int unsigned eff_cols();
      return (cols > COLS_LIMIT) ? 32'(COLS_LIMIT) : 32'(cols);
    endfunction

    function void write_reg(jfps_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        jfps_pkg::REG_INTERIOR_ROWS: rows = v[ROWS_W-1:0];
        jfps_pkg::REG_INTERIOR_COLS: cols = v[COLS_W-1:0];
        default: ;
      endcase
    endfunction

    function sample_t floor_mean(sample_t a, sample_t b, sample_t c, sample_t d);
      logic [SAMPLE_W+1:0] s;
      s = {{2{a[SAMPLE_W-1]}}, a} + {{2{b[SAMPLE_W-1]}}, b}
        + {{2{c[SAMPLE_W-1]}}, c} + {{2{d[SAMPLE_W-1]}}, d};
      return s[SAMPLE_W+1:2];
    endfunction

    function void note_input(sample_t x);
      int unsigned     nc;
      int unsigned     nr;
      int unsigned     c;
      int unsigned     r;
      sample_t         old_mid;
      sample_t         right;
      stencil_result_t res;
      nc = eff_cols();
      nr = 32'(rows);
      c  = 32'(col_pos);
      r  = 32'(row_pos);
      samples_seen++;
      old_mid = middle_row[c];
      if (r >= 2 && r <= nr + 1 && c >= 1 && c <= nc) begin
        right = (c + 1 < MAX_PADDED_COLS) ? middle_row[c+1] : '0;
        res.average = floor_mean(left_val, right, upper_row[c], x);
        res.is_last = (r == nr + 1 && c == nc);
        pending.push_back(res);
      end
      upper_row[c]  = old_mid;
      middle_row[c] = x;
      left_val      = old_mid;
      if (c >= nc + 1) begin
        col_pos = '0;
        row_pos = (r >= nr + 1) ? '0 : ROW_W'(r + 1);
      end else begin
        col_pos = COLS_W'(c + 1);
      end
    endfunction

    function void check_result(sample_t avg, logic is_last);
      stencil_result_t want;
      if (pending.size() == 0) begin
        $error("average: expected nothing, actual %h", avg);
        errors++;
        return;
      end
      want = pending.pop_front();
      results_seen++;
      if (avg !== want.average) begin
        $error("average: expected %h, actual %h", want.average, avg);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("last: expected %b, actual %b", want.is_last, is_last);
        errors++;
      end
    endfunction

    // samples still owed to reach the start of the next grid
    function int unsigned samples_left();
      int unsigned nc;
      int unsigned c;
      int unsigned r;
      int unsigned n;
      nc = eff_cols();
      c  = 32'(col_pos);
      r  = 32'(row_pos);
      n  = 0;
      do begin
        n++;
        if (c >= nc + 1) begin
          c = 0;
          r = (r >= 32'(rows) + 1) ? 0 : r + 1;
        end else begin
          c++;
        end
      end while (r != 0 || c != 0);
      return n;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  sample_t               in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  sample_t               out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  stencil_scoreboard sb;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       quiet_cycles   = 0;
  int unsigned       grids_sent     = 0;

  jacobi_four_point_stencil u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] average
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return MOST_POS;
      1: return MOST_NEG;
      2: return sample_t'($urandom_range(8)) - 4;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic send_sample(input sample_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_sample(rand_sample());
  endtask

  task automatic send_grid(input int unsigned rows, input int unsigned cols);
    int unsigned nc;
    nc = (cols > COLS_LIMIT) ? 32'(COLS_LIMIT) : cols;
    send_random((rows + 2) * (nc + 2));
    grids_sent++;
  endtask

  // hold off until every expected average is out and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned rows, input int unsigned cols);
    cfg_we    <= 1'b1;
    cfg_addr  <= jfps_pkg::REG_INTERIOR_ROWS;
    cfg_wdata <= CFG_DATA_W'(rows);
    @(posedge clk);
    sb.write_reg(jfps_pkg::REG_INTERIOR_ROWS, CFG_DATA_W'(rows));
    cfg_addr  <= jfps_pkg::REG_INTERIOR_COLS;
    cfg_wdata <= CFG_DATA_W'(cols);
    @(posedge clk);
    sb.write_reg(jfps_pkg::REG_INTERIOR_COLS, CFG_DATA_W'(cols));
    cfg_we    <= 1'b0;
  endtask

  task automatic finish_grid();
    send_random(sb.samples_left());
    grids_sent++;
  endtask

  initial begin
    sample_t     corner_grid [12];
    int unsigned random_sent;
    int unsigned rows;
    int unsigned cols;
    int unsigned pick;
    int unsigned phase;
    sb = new();
    corner_grid = '{'0, MOST_POS, MOST_NEG, '0,
                    MOST_POS, MOST_NEG, MOST_POS, MOST_NEG,
                    '0, MOST_POS, MOST_NEG, '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two interior points: one whose neighbours are all the most positive value, the other all the most negative
    set_grid(1, 2);
    foreach (corner_grid[i]) send_sample(corner_grid[i]);
    grids_sent++;
    drain();
    set_grid(0, 1);
    send_grid(0, 1);
    drain();
    set_grid(1, 0);
    send_grid(1, 0);
    drain();

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    // column count above the 1022 limit clamps, then shrink it mid-row
    set_grid(1, 1023);
    send_random(1024 + 2);
    drain();
    set_grid(1, 3);
    finish_grid();
    drain();
    // deepest row count, then shrink it mid-grid so the row counter wraps
    set_grid(65535, 1);
    send_random(12 * 3 + 1);
    drain();
    set_grid(2, 1);
    finish_grid();
    drain();
    // shrink the column count mid-row
    set_grid(4, 16);
    send_random(3 * 18 + 9);
    drain();
    set_grid(4, 5);
    finish_grid();
    send_grid(4, 5);

    rows = 4;
    cols = 5;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      random_sent = 0;
      while (random_sent < RANDOM_SAMPLES / 4) begin
        if ($urandom_range(2) == 0) begin
          rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
          pick = $urandom_range(19);
          cols = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(20, 60) : $urandom_range(1, 10);
          drain();
          set_grid(rows, cols);
        end
        send_grid(rows, cols);
        random_sent += (rows + 2) * (cols + 2);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Streamed %0d samples in %0d grids and checked %0d averages.",
             sb.samples_seen, grids_sent, sb.results_seen);
    $display("Rows 0..65535, columns 0..1023 with clamping, mid-grid resizes, stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
